@@ rtl/sbm_pkg.sv @@
// Package for the swap slot bitmap allocator: map sizes, field widths, opcodes
// and the lowest-zero-bit helper. No dependencies.
`default_nettype none

package sbm_pkg;

  localparam int MAP_BYTES   = 4096;
  localparam int SLOT_W      = 15;
  localparam int BYTE_W      = 8;
  localparam int BIT_W       = 3;
  localparam int BYTE_IDX_W  = SLOT_W - BIT_W;
  localparam int INDEX_BYTES = 2 ** BYTE_IDX_W;
  // Only the bytes a slot number can reach are stored and scanned.
  localparam int SCAN_BYTES  = (MAP_BYTES < INDEX_BYTES) ? MAP_BYTES : INDEX_BYTES;
  localparam int ADDR_W      = (SCAN_BYTES > 1) ? $clog2(SCAN_BYTES) : 1;

  localparam logic [BYTE_W-1:0] BYTE_ALL_ONES = '1;

  typedef enum logic {
    OP_FIND  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Position of the lowest clear bit; only meaningful when the byte is not all ones.
  function automatic logic [BIT_W-1:0] first_zero(input logic [BYTE_W-1:0] b);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int j = BYTE_W - 1; j >= 0; j--) begin
      if (!b[j]) begin
        pos = BIT_W'(j);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sbm_ifs.sv @@
// Request and response channel interfaces of the swap slot bitmap allocator.
// Depends on sbm_pkg for the field widths.
`default_nettype none

interface sbm_req_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [sbm_pkg::SLOT_W-1:0] slot_index;
  logic                      slot_value;

  modport source (output valid, opcode, slot_index, slot_value, input ready);
  modport sink   (input valid, opcode, slot_index, slot_value, output ready);
endinterface

interface sbm_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [sbm_pkg::SLOT_W-1:0] free_slot;
  logic                      map_full;

  modport source (output valid, free_slot, map_full, input ready);
  modport sink   (input valid, free_slot, map_full, output ready);
endinterface

`default_nettype wire

@@ rtl/sbm_ram.sv @@
// Generic single-clock RAM, one write port and one read port, registered read data.
// No dependencies.
`default_nettype none

module sbm_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sbm_ctrl.sv @@
// Sequencer of the swap slot bitmap allocator: clearing pass, bit write by
// read-modify-write, byte scan for a find, and the result register.
// Depends on sbm_pkg and sbm_ifs.
`default_nettype none

module sbm_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  sbm_req_if.sink                             req,
  sbm_rsp_if.source                           rsp,
  output logic                                ram_we,
  output logic      [sbm_pkg::ADDR_W-1:0]     ram_waddr,
  output logic      [sbm_pkg::BYTE_W-1:0]     ram_wdata,
  output logic                                ram_re,
  output logic      [sbm_pkg::ADDR_W-1:0]     ram_raddr,
  input  wire logic [sbm_pkg::BYTE_W-1:0]     ram_rdata
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    WR_MOD,
    SCAN,
    HOLD
  } state_t;

  state_t                         state;
  logic [sbm_pkg::ADDR_W-1:0]     addr;
  logic [sbm_pkg::BIT_W-1:0]      wr_bit;
  logic                           wr_val;
  logic                           out_valid;
  logic [sbm_pkg::SLOT_W-1:0]     out_slot;
  logic                           out_full;
  logic [sbm_pkg::SLOT_W-1:0]     pend_slot;
  logic                           pend_full;

  logic                           accept;
  logic                           is_write;
  logic [sbm_pkg::BYTE_IDX_W-1:0] req_byte;
  logic [sbm_pkg::ADDR_W-1:0]     req_addr;
  logic                           in_range;
  logic                           last;
  logic                           hit;
  logic [sbm_pkg::BYTE_W-1:0]     mod_byte;
  logic                           done;
  logic [sbm_pkg::SLOT_W-1:0]     done_slot;
  logic                           done_full;
  logic                           out_free;
  logic                           load_out;

  assign req.ready = (state == IDLE);
  assign accept    = req.valid && req.ready;
  assign is_write  = (req.opcode == sbm_pkg::OP_WRITE);
  assign req_byte  = req.slot_index[sbm_pkg::SLOT_W-1:sbm_pkg::BIT_W];
  assign req_addr  = req_byte[sbm_pkg::ADDR_W-1:0];
  assign in_range  = ({1'b0, req_byte} < (sbm_pkg::BYTE_IDX_W + 1)'(sbm_pkg::SCAN_BYTES));
  assign last      = (addr == sbm_pkg::ADDR_W'(sbm_pkg::SCAN_BYTES - 1));
  assign hit       = (ram_rdata != sbm_pkg::BYTE_ALL_ONES);
  assign out_free  = !out_valid || rsp.ready;
  assign load_out  = (done || (state == HOLD)) && out_free;

  assign rsp.valid     = out_valid;
  assign rsp.free_slot = out_slot;
  assign rsp.map_full  = out_full;

  always_comb begin
    mod_byte         = ram_rdata;
    mod_byte[wr_bit] = wr_val;
  end

  // Which cycle finishes a transaction, and with what result.
  always_comb begin
    done      = 1'b0;
    done_slot = '0;
    done_full = 1'b0;
    case (state)
      IDLE: begin
        done = accept && is_write && !in_range;
      end
      WR_MOD: begin
        done = 1'b1;
      end
      SCAN: begin
        if (hit) begin
          done      = 1'b1;
          done_slot = sbm_pkg::SLOT_W'({addr, sbm_pkg::first_zero(ram_rdata)});
        end else if (last) begin
          done      = 1'b1;
          done_full = 1'b1;
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_comb begin
    ram_we    = (state == CLEAR) || (state == WR_MOD);
    ram_waddr = addr;
    ram_wdata = (state == CLEAR) ? '0 : mod_byte;
    ram_re    = 1'b0;
    ram_raddr = addr + 1'b1;
    case (state)
      IDLE: begin
        ram_re    = accept && (!is_write || in_range);
        ram_raddr = is_write ? req_addr : '0;
      end
      SCAN: begin
        ram_re = 1'b1;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      addr      <= '0;
      out_valid <= 1'b0;
    end else begin
      // Deliver the result, from the parked copy when one waits.
      if (load_out) begin
        out_valid <= 1'b1;
        out_slot  <= (state == HOLD) ? pend_slot : done_slot;
        out_full  <= (state == HOLD) ? pend_full : done_full;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      // Park the result while the previous one waits.
      if (done && !out_free) begin
        pend_slot <= done_slot;
        pend_full <= done_full;
      end

      case (state)
        CLEAR: begin
          if (last) begin
            addr  <= '0;
            state <= IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        IDLE: begin
          if (accept) begin
            if (is_write) begin
              if (in_range) begin
                addr   <= req_addr;
                wr_bit <= req.slot_index[sbm_pkg::BIT_W-1:0];
                wr_val <= req.slot_value;
                state  <= WR_MOD;
              end else if (!out_free) begin
                state <= HOLD;
              end
            end else begin
              addr  <= '0;
              state <= SCAN;
            end
          end
        end
        WR_MOD: begin
          state <= out_free ? IDLE : HOLD;
        end
        SCAN: begin
          if (done) begin
            state <= out_free ? IDLE : HOLD;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        HOLD: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/swap_slot_bitmap_allocator_unit.sv @@
// Swap slot bitmap allocator: one bit per slot in a byte-wide RAM.
// Reset starts a clearing pass over all SCAN_BYTES bytes with req.ready low.
// A write reads its byte, then modifies it and writes it back; a write beyond the
// map does not touch the RAM and gives its result from the idle state. A find reads
// one byte per cycle from byte 0 until the first byte that is not full, or to the end.
// One transaction at a time; a finished result waits in an output register.
`default_nettype none

module swap_slot_bitmap_allocator_unit (
  input wire logic  clk,
  input wire logic  rst,
  sbm_req_if.sink   req,
  sbm_rsp_if.source rsp
);

  logic                          ram_we;
  logic [sbm_pkg::ADDR_W-1:0]    ram_waddr;
  logic [sbm_pkg::BYTE_W-1:0]    ram_wdata;
  logic                          ram_re;
  logic [sbm_pkg::ADDR_W-1:0]    ram_raddr;
  logic [sbm_pkg::BYTE_W-1:0]    ram_rdata;

  sbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  sbm_ram #(
    .DEPTH (sbm_pkg::SCAN_BYTES),
    .WIDTH (sbm_pkg::BYTE_W),
    .AW    (sbm_pkg::ADDR_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

@@ rtl/sbm_checker.sv @@
// Port-level checks for the swap slot bitmap allocator, bound to the top level.
// Depends on sbm_pkg and on swap_slot_bitmap_allocator_unit.
`default_nettype none

module sbm_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       req_ready,
  input wire logic                       rsp_valid,
  input wire logic                       rsp_ready,
  input wire logic [sbm_pkg::SLOT_W-1:0] free_slot,
  input wire logic                       map_full
);

  // The clearing pass follows every reset: no transaction taken yet.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !req_ready)
    else $error("request taken during clearing pass");

  a_no_rsp_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response shown straight after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("stalled response dropped");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(free_slot) && $stable(map_full))
    else $error("stalled response changed");

  a_full_zero_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && map_full |-> free_slot == '0)
    else $error("full map reported with a non-zero slot");

endmodule

bind swap_slot_bitmap_allocator_unit sbm_checker u_sbm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .free_slot (rsp.free_slot),
  .map_full  (rsp.map_full)
);

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for swap_slot_bitmap_allocator_unit: queued requests with
// random gaps, a mirror of the slot map for expected replies, in-order checking.
// Depends on sbm_pkg and the request/response interfaces in sbm_ifs.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_OPS     = 120;
  localparam int HOLD_AT        = 25;
  localparam int HOLD_LEN       = 400;
  localparam int GAP_PCT        = 9;

  typedef struct packed {
    sbm_pkg::op_t               opcode;
    logic [sbm_pkg::SLOT_W-1:0] slot_index;
    logic                       slot_value;
    logic                       claim;      // take the slot index from the last find
  } slot_op_t;

  typedef struct packed {
    logic [sbm_pkg::SLOT_W-1:0] free_slot;
    logic                       map_full;
  } slot_reply_t;

  logic clk;
  logic rst;

  sbm_req_if req_ch ();
  sbm_rsp_if rsp_ch ();

  swap_slot_bitmap_allocator_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  slot_op_t    slot_ops_pending[$];
  slot_reply_t slot_replies_due[$];
  logic [sbm_pkg::BYTE_W-1:0] slot_bits [sbm_pkg::SCAN_BYTES];
  logic [sbm_pkg::SLOT_W-1:0] last_found;

  slot_op_t    in_flight;
  slot_op_t    next_op;
  slot_reply_t due_reply;
  slot_reply_t exp_reply;

  int ops_accepted;
  int replies_seen;
  int fail_count;
  int hold_left;
  int stall_cycles;
  int find_count;
  int full_count;
  int write_count;
  int deepest_slot;
  bit timed_out;

  // Mirror of the slot map: a find reports the lowest clear bit, a write sets or clears one bit.
  function automatic slot_reply_t predict_slot_op(slot_op_t op);
    slot_reply_t reply;
    logic        found;
    int          byte_no;
    int          bit_no;
    reply = '0;
    found = 1'b0;
    if (op.opcode == sbm_pkg::OP_FIND) begin
      for (int i = 0; i < sbm_pkg::SCAN_BYTES && !found; i++) begin
        if (slot_bits[i] != sbm_pkg::BYTE_ALL_ONES) begin
          for (int j = 0; j < sbm_pkg::BYTE_W && !found; j++) begin
            if (!slot_bits[i][j]) begin
              found = 1'b1;
              reply.free_slot = sbm_pkg::SLOT_W'(i * sbm_pkg::BYTE_W + j);
            end
          end
        end
      end
      reply.map_full = !found;
      last_found = reply.free_slot;
    end else begin
      byte_no = int'(op.slot_index) / sbm_pkg::BYTE_W;
      bit_no  = int'(op.slot_index) % sbm_pkg::BYTE_W;
      if (byte_no < sbm_pkg::SCAN_BYTES) begin
        slot_bits[byte_no][bit_no] = op.slot_value;
      end
    end
    return reply;
  endfunction

  task automatic queue_op(sbm_pkg::op_t opcode, int slot_index, bit slot_value, bit claim);
    slot_op_t op;
    op.opcode     = opcode;
    op.slot_index = sbm_pkg::SLOT_W'(slot_index);
    op.slot_value = slot_value;
    op.claim      = claim;
    slot_ops_pending.push_back(op);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Request driver: predict on acceptance, then present the next queued request.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        due_reply = predict_slot_op(in_flight);
        slot_replies_due.push_back(due_reply);
        ops_accepted++;
        if (in_flight.opcode == sbm_pkg::OP_FIND) begin
          find_count++;
          if (due_reply.map_full) full_count++;
          else if (int'(due_reply.free_slot) > deepest_slot) begin
            deepest_slot = int'(due_reply.free_slot);
          end
        end else begin
          write_count++;
        end
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (slot_ops_pending.size() > 0 &&
            ((ops_accepted >= 40 && ops_accepted < 100) ||
             $urandom_range(0, 99) >= GAP_PCT)) begin
          next_op = slot_ops_pending.pop_front();
          if (next_op.claim) next_op.slot_index = last_found;
          in_flight = next_op;
          req_ch.valid      <= 1'b1;
          req_ch.opcode     <= next_op.opcode;
          req_ch.slot_index <= next_op.slot_index;
          req_ch.slot_value <= next_op.slot_value;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor: compare each transaction with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        replies_seen++;
        if (slot_replies_due.size() == 0) begin
          $error("reply with nothing outstanding: free_slot %0d, map_full %0d",
                 rsp_ch.free_slot, rsp_ch.map_full);
          fail_count++;
        end else begin
          exp_reply = slot_replies_due.pop_front();
          if (rsp_ch.free_slot !== exp_reply.free_slot) begin
            $error("free_slot: expected %0d, got %0d", exp_reply.free_slot, rsp_ch.free_slot);
            fail_count++;
          end
          if (rsp_ch.map_full !== exp_reply.map_full) begin
            $error("map_full: expected %0d, got %0d", exp_reply.map_full, rsp_ch.map_full);
            fail_count++;
          end
        end
        // Hold off once for long enough that the block backs up onto its input.
        if (replies_seen == HOLD_AT) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= (replies_seen >= 45 && replies_seen < 105) ||
                        ($urandom_range(0, 99) >= GAP_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int r;
    int n;
    req_ch.valid      = 1'b0;
    req_ch.opcode     = sbm_pkg::OP_FIND;
    req_ch.slot_index = '0;
    req_ch.slot_value = 1'b0;
    rsp_ch.ready      = 1'b0;
    rst               = 1'b1;
    last_found        = '0;
    foreach (slot_bits[i]) slot_bits[i] = '0;

    // Directed: empty map, fill byte 0 so the scan must skip it, top slot,
    // clearing a free bit, reopening a hole inside a byte.
    queue_op(sbm_pkg::OP_FIND, 0, 1'b0, 1'b0);
    queue_op(sbm_pkg::OP_WRITE, 0, 1'b1, 1'b0);
    queue_op(sbm_pkg::OP_FIND, 0, 1'b0, 1'b0);
    for (int k = 1; k < sbm_pkg::BYTE_W; k++) queue_op(sbm_pkg::OP_WRITE, k, 1'b1, 1'b0);
    queue_op(sbm_pkg::OP_FIND, 0, 1'b0, 1'b0);
    queue_op(sbm_pkg::OP_WRITE, 32767, 1'b1, 1'b0);
    queue_op(sbm_pkg::OP_WRITE, 32767, 1'b0, 1'b0);
    queue_op(sbm_pkg::OP_WRITE, 8, 1'b0, 1'b0);
    queue_op(sbm_pkg::OP_WRITE, 3, 1'b0, 1'b0);
    queue_op(sbm_pkg::OP_FIND, 0, 1'b0, 1'b0);
    queue_op(sbm_pkg::OP_WRITE, 3, 1'b1, 1'b0);
    queue_op(sbm_pkg::OP_FIND, 0, 1'b0, 1'b0);
    queue_op(sbm_pkg::OP_WRITE, 21845, 1'b1, 1'b0);

    // Random: mostly allocate (find then claim), with frees and stray writes.
    n = 0;
    while (n < RANDOM_OPS) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        queue_op(sbm_pkg::OP_FIND, $urandom_range(0, 32767), 1'($urandom_range(0, 1)), 1'b0);
        queue_op(sbm_pkg::OP_WRITE, 0, 1'b1, 1'b1);
        n += 2;
      end else begin
        if (r < 45) begin
          queue_op(sbm_pkg::OP_FIND, $urandom_range(0, 32767),
                   1'($urandom_range(0, 1)), 1'b0);
        end else if (r < 70) begin
          queue_op(sbm_pkg::OP_WRITE, $urandom_range(0, 127), 1'b0, 1'b0);
        end else if (r < 85) begin
          queue_op(sbm_pkg::OP_WRITE, $urandom_range(0, 127),
                   1'($urandom_range(0, 1)), 1'b0);
        end else begin
          queue_op(sbm_pkg::OP_WRITE, $urandom_range(0, 32767),
                   1'($urandom_range(0, 1)), 1'b0);
        end
        n++;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (!timed_out && !(slot_ops_pending.size() == 0 && !req_ch.valid &&
                           slot_replies_due.size() == 0)) begin
      @(negedge clk);
      timed_out = stall_cycles >= WATCHDOG_LIMIT;
    end
    for (int k = 0; k < SETTLE_CYCLES && !timed_out; k++) begin
      @(negedge clk);
      timed_out = stall_cycles >= WATCHDOG_LIMIT;
    end
    if (timed_out) begin
      $error("no transaction for %0d cycles, %0d replies outstanding",
             stall_cycles, slot_replies_due.size());
    end

    $display("requests %0d: %0d finds (%0d on a full map, deepest free slot %0d), %0d writes",
             ops_accepted, find_count, full_count, deepest_slot, write_count);
    $display("replies checked %0d, field mismatches %0d", replies_seen, fail_count);
    if (fail_count == 0 && !timed_out) begin
      $display("swap_slot_bitmap_allocator_unit: match");
    end else begin
      $display("swap_slot_bitmap_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sbm_pkg.sv
rtl/sbm_ifs.sv
rtl/sbm_ram.sv
rtl/sbm_ctrl.sv
rtl/swap_slot_bitmap_allocator_unit.sv
rtl/sbm_checker.sv
bench/tb.sv
